// File: rtl/swdr_pkg.sv
`default_nettype none

package swdr_pkg;

    localparam int WORD_W   = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_DEDUP = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [WORD_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] pop_value;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       entry_count;
    } t_out_item;

endpackage

`default_nettype wire

// File: rtl/swdr_mem.sv
`default_nettype none

module swdr_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [AW-1:0]                i_waddr,
    input  wire logic [swdr_pkg::WORD_W-1:0]  i_wdata,
    input  wire logic                         i_re,
    input  wire logic [AW-1:0]                i_raddr,
    output      logic [swdr_pkg::WORD_W-1:0]  o_rdata
);

    logic [swdr_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [swdr_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/stack_with_duplicate_removal.sv
`default_nettype none

// Bounded LIFO stack of signed 32-bit words held in one synchronous RAM of DEPTH
// entries, with a fill count in flip-flops (no clearing pass after reset). Push,
// an unused op code, remove-duplicates on an empty stack and any refused
// operation (pop when empty, push when full) load the result register on
// acceptance, so the next item can be taken as soon as that register is free.
// Pop reads the top word through the registered RAM read port and loads the
// result from S_DONE. Remove-duplicates walks the stack through the single RAM
// read port: each entry i costs one read of itself plus one read for each entry
// above it up to the first equal one. Results leave through an output register;
// while a result waits under stall, the input stays stalled too.
module stack_with_duplicate_removal #(
    parameter int DEPTH = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output      logic                  o_in_stall,
    input  wire swdr_pkg::t_in_item    i_in_data,
    output      logic                  o_out_valid,
    input  wire logic                  i_out_stall,
    output      swdr_pkg::t_out_item   o_out_data
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CNT_W = swdr_pkg::COUNT_W;
    localparam int WW    = swdr_pkg::WORD_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DD_V,
        S_DD_J,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_i, n_i;
    logic [CW-1:0]       r_j, n_j;
    logic [CW-1:0]       r_w, n_w;
    logic [WW-1:0]       r_v, n_v;
    logic                r_is_pop, n_is_pop;
    logic                r_out_valid, n_out_valid;
    swdr_pkg::t_out_item r_out, n_out;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [WW-1:0]       mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [WW-1:0]       mem_rdata;

    logic                out_free;
    logic                accept;
    logic [CW-1:0]       i_inc;
    logic [CW-1:0]       j_inc;
    logic [CW-1:0]       w_inc;
    logic [CW-1:0]       cnt_inc;
    logic [CW-1:0]       cnt_dec;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign accept     = i_in_valid && !o_in_stall;

    assign i_inc   = r_i + ONE_C;
    assign j_inc   = r_j + ONE_C;
    assign w_inc   = r_w + ONE_C;
    assign cnt_inc = r_count + ONE_C;
    assign cnt_dec = r_count - ONE_C;

    swdr_mem #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_swdr_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_i         = r_i;
        n_j         = r_j;
        n_w         = r_w;
        n_v         = r_v;
        n_is_pop    = r_is_pop;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_w[AW-1:0];
        mem_wdata   = mem_rdata;
        mem_re      = 1'b0;
        mem_raddr   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out.pop_value   = '0;
                    n_out.status      = swdr_pkg::ST_OK;
                    n_out.entry_count = CNT_W'(r_count);
                    unique case (i_in_data.op)
                        swdr_pkg::OP_PUSH: begin
                            n_out_valid = 1'b1;
                            if (r_count == DEPTH_C) begin
                                n_out.status = swdr_pkg::ST_FULL;
                            end else begin
                                mem_we            = 1'b1;
                                mem_waddr         = r_count[AW-1:0];
                                mem_wdata         = i_in_data.push_value;
                                n_count           = cnt_inc;
                                n_out.entry_count = CNT_W'(cnt_inc);
                            end
                        end
                        swdr_pkg::OP_POP: begin
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out.status = swdr_pkg::ST_EMPTY;
                            end else begin
                                // Word arrives from the RAM next cycle
                                mem_re    = 1'b1;
                                mem_raddr = cnt_dec[AW-1:0];
                                n_count   = cnt_dec;
                                n_is_pop  = 1'b1;
                                n_state   = S_DONE;
                            end
                        end
                        swdr_pkg::OP_DEDUP: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = '0;
                                n_i       = '0;
                                n_w       = '0;
                                n_is_pop  = 1'b0;
                                n_state   = S_DD_V;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_DD_V: begin
                // Candidate word for entry i is on the read port
                n_v = mem_rdata;
                if (i_inc < r_count) begin
                    n_j       = i_inc;
                    mem_re    = 1'b1;
                    mem_raddr = i_inc[AW-1:0];
                    n_state   = S_DD_J;
                end else begin
                    // Topmost entry is always kept; walk ends here
                    mem_we    = 1'b1;
                    mem_waddr = r_w[AW-1:0];
                    mem_wdata = mem_rdata;
                    n_w       = w_inc;
                    n_count   = w_inc;
                    n_state   = S_DONE;
                end
            end
            S_DD_J: begin
                if (mem_rdata == r_v) begin
                    // Drop: an equal word lies above
                    n_i       = i_inc;
                    mem_re    = 1'b1;
                    mem_raddr = i_inc[AW-1:0];
                    n_state   = S_DD_V;
                end else if (j_inc < r_count) begin
                    n_j       = j_inc;
                    mem_re    = 1'b1;
                    mem_raddr = j_inc[AW-1:0];
                end else begin
                    // Keep: compact toward the bottom, never past the read point
                    mem_we    = 1'b1;
                    mem_waddr = r_w[AW-1:0];
                    mem_wdata = r_v;
                    n_w       = w_inc;
                    n_i       = i_inc;
                    mem_re    = 1'b1;
                    mem_raddr = i_inc[AW-1:0];
                    n_state   = S_DD_V;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out.pop_value   = r_is_pop ? mem_rdata : '0;
                    n_out.status      = swdr_pkg::ST_OK;
                    n_out.entry_count = CNT_W'(r_count);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_i      <= n_i;
        r_j      <= n_j;
        r_w      <= n_w;
        r_v      <= n_v;
        r_is_pop <= n_is_pop;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: rtl/swdr_chk.sv
`default_nettype none

module swdr_chk #(
    parameter int DEPTH = 16
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_out_valid,
    input wire logic                  i_out_stall,
    input wire swdr_pkg::t_out_item   i_out_data
);

    localparam int CNT_W = swdr_pkg::COUNT_W;

    // Stalled result transfer stays offered
    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_out_valid && i_out_stall) |-> i_out_valid)
        else $error("result withdrawn while stalled");

    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_out_valid && i_out_stall) |-> $stable(i_out_data))
        else $error("result changed while stalled");

    // Refused operations return no word
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.status != swdr_pkg::ST_OK)
            |-> (i_out_data.pop_value == '0))
        else $error("error result carries a word");

    // Error codes agree with the reported fill
    a_err_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && ((i_out_data.status == swdr_pkg::ST_EMPTY
                         && i_out_data.entry_count != '0)
                     || (i_out_data.status == swdr_pkg::ST_FULL
                         && i_out_data.entry_count != CNT_W'(DEPTH))) |-> 1'b0)
        else $error("status disagrees with entry count");

endmodule

bind stack_with_duplicate_removal swdr_chk #(
    .DEPTH(DEPTH)
) u_swdr_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .i_out_data (o_out_data)
);

`default_nettype wire
